// ===== sv/hi3e_pkg.sv =====
// Shared widths and word types for the 3-D Hilbert index encoder.
package hi3e_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned INDEX_W = 30;
    localparam int unsigned NDIM    = 3;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [INDEX_W-1:0] index_t;

endpackage

// ===== sv/hi3e_coord_if.sv =====
// Valid/ready channel that carries one cell coordinate and its level.
interface hi3e_coord_if
    import hi3e_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
    level_t level;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    output level, input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    input level, output ready);
endinterface

// ===== sv/hi3e_index_if.sv =====
// Valid/ready channel that carries one Hilbert curve index.
interface hi3e_index_if
    import hi3e_pkg::*;
;
    logic   valid;
    logic   ready;
    index_t hilbert_index;

    modport source (output valid, output hilbert_index, input ready);
    modport sink   (input valid, input hilbert_index, output ready);
endinterface

// ===== sv/hilbert_index_3d_encode_top.sv =====
// 3-D Hilbert curve index encoder (Skilling's method), fully pipelined.
//
// Usage: the coord channel takes one word per cycle while coord.ready is high,
// holding coord_x, coord_y, coord_z and level; the index channel returns one word
// holding hilbert_index for each coordinate word, in order. Coordinate bits at or
// above the level are ignored, and a level above MAX_LEVEL is treated as MAX_LEVEL.
//
// Each accepted word moves through the registered stages in order, one word per
// cycle while the receiver is ready: stage 0 masks the coordinates, stages 1 to
// MAX_LEVEL-1 each apply one level of the invert-or-exchange step, and the output
// register holds the Gray-coded and interleaved index. The depth of that level
// chain sets the latency.
//
// Reset clears all valid bits; the pipeline is empty afterwards and coord.ready
// is high. When the receiver stalls, each stage holds its word and ready ripples
// back stage by stage, so empty stages keep filling until the pipeline is full.
module hilbert_index_3d_encode_top
    import hi3e_pkg::*;
#(
    parameter int unsigned MAX_LEVEL = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    hi3e_coord_if.sink    coord,
    hi3e_index_if.source  index
);

    localparam int unsigned W  = MAX_LEVEL;
    localparam int unsigned LW = $clog2(MAX_LEVEL + 1);
    localparam int unsigned HW = NDIM * W;

    logic [W-1:0]  a_reg   [W][NDIM];
    logic [LW-1:0] lev_reg [W];
    logic          v_reg   [W];
    logic          rdy     [W+1];

    index_t        idx_reg;
    logic          idx_valid_reg;

    // Ready ripples back from the output register toward the input.
    always_comb
    begin
        rdy[W] = !idx_valid_reg || index.ready;
        for (int s = W - 1; s >= 0; s--)
        begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    assign coord.ready = rdy[0];

    // Stage 0: saturate the level and keep only the low level bits of each axis.
    logic [LW-1:0]     lev_next;
    logic [W-1:0]      in_next [NDIM];
    logic [W+COORD_W-1:0] ext_x, ext_y, ext_z;
    logic [W-1:0]      lowmask;

    always_comb
    begin
        lev_next = (32'(coord.level) > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(coord.level);
        for (int j = 0; j < W; j++)
        begin
            lowmask[j] = (LW'(j) < lev_next);
        end
        ext_x = (W + COORD_W)'(coord.coord_x);
        ext_y = (W + COORD_W)'(coord.coord_y);
        ext_z = (W + COORD_W)'(coord.coord_z);
        in_next[0] = ext_x[W-1:0] & lowmask;
        in_next[1] = ext_y[W-1:0] & lowmask;
        in_next[2] = ext_z[W-1:0] & lowmask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            v_reg[0] <= coord.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && coord.valid)
        begin
            a_reg[0][0] <= in_next[0];
            a_reg[0][1] <= in_next[1];
            a_reg[0][2] <= in_next[2];
            lev_reg[0]  <= lev_next;
        end
    end

    // Stages 1 to W-1: one invert-or-exchange level each, top level first.
    for (genvar s = 1; s < W; s++)
    begin : g_level
        localparam int unsigned K = W - s;
        localparam logic [W-1:0] P = W'((64'd1 << K) - 64'd1);

        logic [W-1:0] a_next [NDIM];
        logic [W-1:0] t1, t2;
        logic         active;

        always_comb
        begin
            active    = (lev_reg[s-1] > LW'(K));
            a_next[0] = a_reg[s-1][0];
            a_next[1] = a_reg[s-1][1];
            a_next[2] = a_reg[s-1][2];
            t1 = '0;
            t2 = '0;
            if (active)
            begin
                // Axis 0 against itself only ever inverts.
                if (a_next[0][K])
                begin
                    a_next[0] = a_next[0] ^ P;
                end
                if (a_next[1][K])
                begin
                    a_next[0] = a_next[0] ^ P;
                end
                else
                begin
                    t1 = (a_next[0] ^ a_next[1]) & P;
                    a_next[0] = a_next[0] ^ t1;
                    a_next[1] = a_next[1] ^ t1;
                end
                if (a_next[2][K])
                begin
                    a_next[0] = a_next[0] ^ P;
                end
                else
                begin
                    t2 = (a_next[0] ^ a_next[2]) & P;
                    a_next[0] = a_next[0] ^ t2;
                    a_next[2] = a_next[2] ^ t2;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && v_reg[s-1])
            begin
                a_reg[s][0] <= a_next[0];
                a_reg[s][1] <= a_next[1];
                a_reg[s][2] <= a_next[2];
                lev_reg[s]  <= lev_reg[s-1];
            end
        end
    end

    // Output stage: Gray encode across axes, apply the correction, interleave.
    logic [W-1:0]        g0, g1, g2, corr;
    logic [HW-1:0]       h;
    logic [HW+INDEX_W-1:0] h_ext;
    index_t              idx_next;

    always_comb
    begin
        g0 = a_reg[W-1][0];
        g1 = a_reg[W-1][1] ^ g0;
        g2 = a_reg[W-1][2] ^ g1;
        // Each correction bit is the parity of the last axis above that bit.
        for (int j = 0; j < W; j++)
        begin
            corr[j] = ^(g2 >> (j + 1));
        end
        g0 = g0 ^ corr;
        g1 = g1 ^ corr;
        g2 = g2 ^ corr;
        for (int b = 0; b < W; b++)
        begin
            h[NDIM*b]     = g2[b];
            h[NDIM*b + 1] = g1[b];
            h[NDIM*b + 2] = g0[b];
        end
        h_ext    = (HW + INDEX_W)'(h);
        idx_next = h_ext[INDEX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_valid_reg <= 1'b0;
        end
        else if (rdy[W])
        begin
            idx_valid_reg <= v_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[W] && v_reg[W-1])
        begin
            idx_reg <= idx_next;
        end
    end

    assign index.valid         = idx_valid_reg;
    assign index.hilbert_index = idx_reg;

endmodule
